### src/ray_triangle_closest_hit_top_defines.svh
// Assertion macros for the ray/triangle closest-hit block.
`ifndef RAY_TRIANGLE_CLOSEST_HIT_TOP_DEFINES_SVH
`define RAY_TRIANGLE_CLOSEST_HIT_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define RTC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define RTC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RTC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define RTC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### src/rtch_pkg.sv
// Shared types and constants of the ray/triangle closest-hit block.
`default_nettype none
package rtch_pkg;
	localparam int DIST_W = 31;
	localparam int OUT_TAG_W = 16;
	localparam int NREG = 6;
	localparam logic [2:0] REG_OX = 3'd0;
	localparam logic [2:0] REG_OY = 3'd1;
	localparam logic [2:0] REG_OZ = 3'd2;
	localparam logic [2:0] REG_DX = 3'd3;
	localparam logic [2:0] REG_DY = 3'd4;
	localparam logic [2:0] REG_DZ = 3'd5;
endpackage
`default_nettype wire

### src/rtch_front.sv
// Front end: capture a triangle request and stage it toward the queue.
`default_nettype none
module rtch_front #(
	parameter int W = 32,
	parameter int TW = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [9*W+TW:0]   in_item,
	output logic                   q_valid,
	input  wire logic              q_ready,
	output logic [9*W+TW:0]        q_item
);
	import rtch_pkg::*;
	localparam int DEPTH = 2;
	logic [9*W+TW:0] mem_q [DEPTH];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;
	logic            push, pop;

	assign in_ready = (cnt_q != 2'(DEPTH));
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

### src/rtch_back.sv
// Back end: sequenced Moller-Trumbore test, divider and closest-hit tracking.
`default_nettype none
module rtch_back #(
	parameter int W = 32,
	parameter int TW = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [rtch_pkg::NREG*W-1:0] ray,
	input  wire logic                  q_valid,
	output logic                       q_ready,
	input  wire logic [9*W+TW:0]       q_item,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [rtch_pkg::DIST_W+rtch_pkg::OUT_TAG_W:0] out_item
);
	import rtch_pkg::*;
	localparam int EW = W + 1;           // edges, offsets
	localparam int PW = 2 * EW + 1;      // cross products
	localparam int DW = EW + PW + 2;     // dot products
	localparam int NW = DW + 8;          // numerator scaled by 256
	localparam int CW = $clog2(NW + 1);
	localparam int LW = PW - EW;         // low slice of a cross product
	localparam int MW = LW + 1;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_EDGE = 7'b0000010,
		ST_CRS  = 7'b0000100,
		ST_DOT  = 7'b0001000,
		ST_TEST = 7'b0010000,
		ST_DIV  = 7'b0100000,
		ST_OUT  = 7'b1000000
	} st_t;

	st_t st_q;
	logic [9*W+TW:0] it_q;
	logic signed [EW-1:0] e1_q [3], e2_q [3], s_q [3], d_q [3];
	logic signed [PW-1:0] p_q [3], qv_q [3];
	logic signed [DW-1:0] det_q, un_q, vn_q, tn_q;
	logic [1:0] k_q;
	logic hf_q;
	logic [NW-1:0] num_q, quo_q;
	logic [NW:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] bit_q;
	logic have_q;
	logic [31:0] best_t_q;
	logic [TW-1:0] best_tag_q;
	logic [DIST_W+OUT_TAG_W:0] res_q;
	logic res_v_q;

	function automatic logic signed [EW-1:0] crd(input logic [W-1:0] v);
		return EW'($signed(v));
	endfunction

	// component index pairs for the cross product lane k
	logic [1:0] ia, ib;
	always_comb begin
		case (k_q)
			2'd0: begin ia = 2'd1; ib = 2'd2; end
			2'd1: begin ia = 2'd2; ib = 2'd0; end
			default: begin ia = 2'd0; ib = 2'd1; end
		endcase
	end

	logic signed [PW-1:0] pk, qk;
	assign pk = PW'(d_q[ia] * e2_q[ib]) - PW'(d_q[ib] * e2_q[ia]);
	assign qk = PW'(s_q[ia] * e1_q[ib]) - PW'(s_q[ib] * e1_q[ia]);

	// multiply each cross-product lane in two slices: low unsigned, then high signed
	logic signed [MW-1:0] pm, qm;
	assign pm = hf_q ? MW'($signed(p_q[k_q][PW-1:LW])) : $signed({1'b0, p_q[k_q][LW-1:0]});
	assign qm = hf_q ? MW'($signed(qv_q[k_q][PW-1:LW])) : $signed({1'b0, qv_q[k_q][LW-1:0]});

	logic signed [DW-1:0] m_det, m_un, m_vn, m_tn;
	assign m_det = DW'(e1_q[k_q] * pm);
	assign m_un  = DW'(s_q[k_q] * pm);
	assign m_vn  = DW'(d_q[k_q] * qm);
	assign m_tn  = DW'(e2_q[k_q] * qm);

	logic signed [DW-1:0] a_det, a_un, a_vn, a_tn;
	assign a_det = hf_q ? (m_det <<< LW) : m_det;
	assign a_un  = hf_q ? (m_un <<< LW) : m_un;
	assign a_vn  = hf_q ? (m_vn <<< LW) : m_vn;
	assign a_tn  = hf_q ? (m_tn <<< LW) : m_tn;

	logic neg;
	logic signed [DW-1:0] nd, nu, nv, nt;
	logic hit;
	assign neg = det_q[DW-1];
	assign nd = neg ? -det_q : det_q;
	assign nu = neg ? -un_q : un_q;
	assign nv = neg ? -vn_q : vn_q;
	assign nt = neg ? -tn_q : tn_q;
	assign hit = (det_q != '0) && !nu[DW-1] && (nu <= nd) && !nv[DW-1]
		&& ((nu + nv) <= nd) && !nt[DW-1];

	logic [NW:0] rsh;
	assign rsh = {rem_q[NW-1:0], num_q[NW-1]};

	logic [31:0] t_sat;
	assign t_sat = (quo_q[NW-1:DIST_W] != '0) ? 32'h7FFFFFFF : 32'(quo_q[DIST_W-1:0]);

	logic is_last;
	assign is_last = it_q[9*W+TW];

	assign q_ready = (st_q == ST_IDLE);
	assign out_valid = res_v_q;
	assign out_item = res_q;

	integer i;
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: if (q_valid) it_q <= q_item;
			ST_EDGE: begin
				for (i = 0; i < 3; i++) begin
					e1_q[i] <= crd(it_q[(3+i)*W +: W]) - crd(it_q[i*W +: W]);
					e2_q[i] <= crd(it_q[(6+i)*W +: W]) - crd(it_q[i*W +: W]);
					s_q[i]  <= crd(ray[i*W +: W]) - crd(it_q[i*W +: W]);
					d_q[i]  <= crd(ray[(3+i)*W +: W]);
				end
				det_q <= '0; un_q <= '0; vn_q <= '0; tn_q <= '0;
			end
			ST_CRS: begin
				p_q[k_q] <= pk;
				qv_q[k_q] <= qk;
			end
			ST_DOT: begin
				det_q <= det_q + a_det;
				un_q <= un_q + a_un;
				vn_q <= vn_q + a_vn;
				tn_q <= tn_q + a_tn;
			end
			ST_TEST: begin
				num_q <= {nt[NW-9:0], 8'd0};
				den_q <= nd;
				rem_q <= '0;
				quo_q <= '0;
			end
			ST_DIV: begin
				// one quotient bit per cycle
				num_q <= {num_q[NW-2:0], 1'b0};
				if (rsh >= {1'b0, {(NW-DW){1'b0}}, den_q}) begin
					rem_q <= rsh - {1'b0, {(NW-DW){1'b0}}, den_q};
					quo_q <= {quo_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= rsh;
					quo_q <= {quo_q[NW-2:0], 1'b0};
				end
			end
			ST_OUT: ;
			default: ;
		endcase
	end

	logic upd;
	logic [31:0] nb_t;
	logic [TW-1:0] nb_tag;
	logic nb_have;
	always_comb begin
		upd = !have_q || (t_sat < best_t_q);
		nb_have = have_q || 1'b1;
		nb_t = upd ? t_sat : best_t_q;
		nb_tag = upd ? it_q[9*W +: TW] : best_tag_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			k_q <= 2'd0;
			hf_q <= 1'b0;
			bit_q <= '0;
			have_q <= 1'b0;
			best_t_q <= '0;
			best_tag_q <= '0;
			res_v_q <= 1'b0;
			res_q <= '0;
		end else begin
			// a last request reloading the slot keeps it valid
			if (out_valid && out_ready && !(st_q == ST_OUT && is_last)) res_v_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (q_valid) st_q <= ST_EDGE;
				ST_EDGE: begin k_q <= 2'd0; hf_q <= 1'b0; st_q <= ST_CRS; end
				ST_CRS: begin
					k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
					if (k_q == 2'd2) st_q <= ST_DOT;
				end
				ST_DOT: begin
					hf_q <= ~hf_q;
					if (hf_q) begin
						k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
						if (k_q == 2'd2) st_q <= ST_TEST;
					end
				end
				ST_TEST: begin
					bit_q <= CW'(NW);
					st_q <= hit ? ST_DIV : ST_OUT;
				end
				ST_DIV: begin
					bit_q <= bit_q - CW'(1);
					if (bit_q == CW'(1)) st_q <= ST_OUT;
				end
				ST_OUT: begin
					// wait for the result slot before the last request reports
					if (!is_last || !res_v_q || out_ready) begin
						logic h; logic [31:0] t; logic [TW-1:0] g;
						h = have_q; t = best_t_q; g = best_tag_q;
						if (bit_q == '0 && den_q != '0 && hit) begin
							h = nb_have; t = nb_t; g = nb_tag;
						end
						if (is_last) begin
							res_v_q <= 1'b1;
							res_q <= {h ? t[DIST_W-1:0] : {DIST_W{1'b0}},
								h ? OUT_TAG_W'(g) : {OUT_TAG_W{1'b0}}, h};
							have_q <= 1'b0;
							best_t_q <= '0;
							best_tag_q <= '0;
						end else begin
							have_q <= h;
							best_t_q <= t;
							best_tag_q <= g;
						end
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### src/ray_triangle_closest_hit_top.sv
// Top level of the ray/triangle closest-hit block.
// The back end takes a triangle through a capture step, an edge step, three
// cross-product steps, six dot-product half steps (each lane is multiplied in a
// low and a high slice), a test step and an output step, plus on a hit a
// one-bit-per-cycle restoring divider for the NW-bit quotient t (NW = 110 at
// COORD_BITS=32). A last triangle holds in its output step while the previous
// result still waits to be taken. A two-entry queue lets the next triangles be
// accepted while one is in work; the result sits in an output register until
// taken. Ray registers are written over APB.
`default_nettype none
`include "ray_triangle_closest_hit_top_defines.svh"
module ray_triangle_closest_hit_top #(
	parameter int TAG_BITS = 16,
	parameter int COORD_BITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [4:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  wire logic s_tvalid,
	output logic s_tready,
	// a_x,a_y,a_z,b_x,b_y,b_z,c_x,c_y,c_z,tri_tag, zero fill
	input  wire logic [((9*COORD_BITS+TAG_BITS+7)/8)*8-1:0] s_tdata,
	input  wire logic s_tlast,
	output logic m_tvalid,
	input  wire logic m_tready,
	// any_hit, hit_tag, hit_distance
	output logic [rtch_pkg::DIST_W+rtch_pkg::OUT_TAG_W:0] m_tdata
);
	import rtch_pkg::*;
	localparam int W = COORD_BITS;
	localparam int TW = TAG_BITS;
	logic [W-1:0] reg_q [NREG];
	logic [NREG*W-1:0] ray;
	logic qv, qr;
	logic [9*W+TW:0] qi;

	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		for (int i = 0; i < NREG; i++) begin
			ray[i*W +: W] = reg_q[i];
			if (paddr[4:2] == 3'(i)) prdata = 32'(reg_q[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NREG; i++) reg_q[i] <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[4:2])
				REG_OX, REG_OY, REG_OZ, REG_DX, REG_DY, REG_DZ:
					reg_q[paddr[4:2]] <= W'(pwdata);
				default: ;
			endcase
		end
	end

	rtch_front #(.W(W), .TW(TW)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.in_item({s_tlast, s_tdata[9*W+TW-1:0]}),
		.q_valid(qv), .q_ready(qr), .q_item(qi)
	);

	rtch_back #(.W(W), .TW(TW)) u_back (
		.clk(clk), .arst_n(arst_n), .ray(ray), .q_valid(qv), .q_ready(qr),
		.q_item(qi), .out_valid(m_tvalid), .out_ready(m_tready), .out_item(m_tdata)
	);

	`RTC_ASSERT_IMP(a_nohit_zero, clk, arst_n, m_tvalid && !m_tdata[0], m_tdata[DIST_W+OUT_TAG_W:1] == '0, "no-hit result carries nonzero fields")
	`RTC_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
endmodule
`default_nettype wire

### dv/tb_ray_triangle_closest_hit_top.sv
// Self-checking testbench for the ray/triangle closest-hit block.
`default_nettype none
module tb_ray_triangle_closest_hit_top;
	import rtch_pkg::*;

	typedef logic signed [191:0] wint_t;

	typedef struct {
		logic [31:0] v[9];
		logic [15:0] tag;
		bit          last;
	} tri_t;

	typedef struct {
		bit          hit;
		logic [15:0] tag;
		logic [30:0] distance;
	} hit_t;

	localparam int WATCHDOG = 5000;
	localparam int DRAIN = 300;
	localparam logic [30:0] DIST_SAT = 31'h7FFFFFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// a_x,a_y,a_z,b_x,b_y,b_z,c_x,c_y,c_z,tri_tag
	logic [303:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// any_hit, hit_tag, hit_distance
	logic [47:0] m_tdata;

	ray_triangle_closest_hit_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	class hit_scoreboard;
		logic [31:0] ray[6];
		bit          have_best;
		logic [30:0] best_t;
		logic [15:0] best_tag;
		hit_t        pending_hits[$];
		int          errors;
		int          n_checked;
		int          n_hits;

		function new();
			foreach (ray[i]) ray[i] = '0;
			have_best = 0;
			best_t = '0;
			best_tag = '0;
			errors = 0;
			n_checked = 0;
			n_hits = 0;
		endfunction

		static function void cross3(input wint_t a[3], input wint_t b[3], output wint_t r[3]);
			r[0] = a[1] * b[2] - a[2] * b[1];
			r[1] = a[2] * b[0] - a[0] * b[2];
			r[2] = a[0] * b[1] - a[1] * b[0];
		endfunction

		static function wint_t dot3(input wint_t a[3], input wint_t b[3]);
			return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
		endfunction

		function bit hits_triangle(input tri_t t, output logic [30:0] d);
			wint_t va[3], e1[3], e2[3], dir[3], s[3], p[3], q[3];
			wint_t det, un, vn, tn, big;
			for (int k = 0; k < 3; k++) begin
				va[k] = $signed(t.v[k]);
				e1[k] = wint_t'($signed(t.v[3 + k])) - va[k];
				e2[k] = wint_t'($signed(t.v[6 + k])) - va[k];
				dir[k] = $signed(ray[3 + k]);
				s[k] = wint_t'($signed(ray[k])) - va[k];
			end
			d = '0;
			cross3(dir, e2, p);
			det = dot3(e1, p);
			if (det == 0) return 0;
			cross3(s, e1, q);
			un = dot3(s, p);
			vn = dot3(dir, q);
			tn = dot3(e2, q);
			if (det < 0) begin
				det = -det;
				un = -un;
				vn = -vn;
				tn = -tn;
			end
			if (un < 0 || un > det) return 0;
			if (vn < 0 || un + vn > det) return 0;
			if (tn < 0) return 0;
			big = (tn * 256) / det;
			d = (big > wint_t'(DIST_SAT)) ? DIST_SAT : big[30:0];
			return 1;
		endfunction

		function void note_triangle(input tri_t t);
			logic [30:0] d;
			hit_t h;
			if (hits_triangle(t, d)) begin
				n_hits++;
				if (!have_best || d < best_t) begin
					have_best = 1;
					best_t = d;
					best_tag = t.tag;
				end
			end
			if (!t.last) return;
			h.hit = have_best;
			h.tag = have_best ? best_tag : '0;
			h.distance = have_best ? best_t : '0;
			pending_hits = {pending_hits, h};
			have_best = 0;
			best_t = '0;
			best_tag = '0;
		endfunction

		function void check_result(input logic [47:0] data);
			hit_t e;
			if (pending_hits.size() == 0) begin
				$error("result with no request pending: %h", data);
				errors++;
				return;
			end
			e = pending_hits.pop_front();
			n_checked++;
			if (data[0] !== e.hit) begin
				$error("any_hit: expected %0d, got %0d", e.hit, data[0]);
				errors++;
			end
			if (data[16:1] !== e.tag) begin
				$error("hit_tag: expected %0d, got %0d", e.tag, data[16:1]);
				errors++;
			end
			if (data[47:17] !== e.distance) begin
				$error("hit_distance: expected %0d, got %0d", e.distance, data[47:17]);
				errors++;
			end
		endfunction
	endclass

	hit_scoreboard sb = new();
	int idle_cycles = 0;
	int n_sent = 0;
	bit timed_out = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG && !timed_out) begin
			timed_out = 1;
			$display("watchdog: no progress for %0d cycles", WATCHDOG);
			$display("tb_ray_triangle_closest_hit_top: done, errors");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.ray[idx] = val;
	endtask

	task automatic set_ray(input logic [31:0] ox, oy, oz, dx, dy, dz);
		write_reg(REG_OX, ox);
		write_reg(REG_OY, oy);
		write_reg(REG_OZ, oz);
		write_reg(REG_DX, dx);
		write_reg(REG_DY, dy);
		write_reg(REG_DZ, dz);
	endtask

	task automatic send_triangle(input tri_t t);
		logic [303:0] packed_tri;
		int gap;
		gap = $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		for (int k = 0; k < 9; k++) packed_tri[32 * k +: 32] = t.v[k];
		packed_tri[303:288] = t.tag;
		s_tvalid <= 1'b1;
		s_tdata <= packed_tri;
		s_tlast <= t.last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_triangle(t);
		n_sent++;
	endtask

	task automatic flush_stream();
		s_tvalid <= 1'b0;
		while (sb.pending_hits.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// triangle with its vertices given as raw coordinates (Q8 scaled by the caller)
	function automatic tri_t flat_tri(input int ax, ay, az, bx, by, bz, cx, cy, cz,
			input logic [15:0] tag, input bit last);
		tri_t t;
		t.v[0] = ax; t.v[1] = ay; t.v[2] = az;
		t.v[3] = bx; t.v[4] = by; t.v[5] = bz;
		t.v[6] = cx; t.v[7] = cy; t.v[8] = cz;
		t.tag = tag;
		t.last = last;
		return t;
	endfunction

	function automatic tri_t rand_tri(input bit wild);
		tri_t t;
		int k;
		int cen[3];
		k = $urandom_range(0, 12);
		for (int i = 0; i < 3; i++)
			cen[i] = $signed(sb.ray[i]) + $signed(sb.ray[3 + i]) * k;
		for (int i = 0; i < 9; i++)
			t.v[i] = wild ? $urandom() : cen[i % 3] + $signed($urandom_range(0, 4096)) - 2048;
		t.tag = $urandom_range(0, 65535);
		t.last = 0;
		return t;
	endfunction

	task automatic random_phase(input int n_items);
		tri_t t;
		int left;
		int set_len;
		left = n_items;
		while (left > 0) begin
			set_len = $urandom_range(1, 5);
			for (int i = 0; i < set_len; i++) begin
				t = rand_tri($urandom_range(0, 99) < 15);
				t.last = (i == set_len - 1);
				send_triangle(t);
			end
			left -= set_len;
		end
		flush_stream();
	endtask

	initial begin
		forever begin
			int gap;
			gap = $urandom_range(0, 3);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			sb.check_result(m_tdata);
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ray from origin along +z, one unit per step
		set_ray(0, 0, 0, 0, 0, 256);
		send_triangle(flat_tri(-256, -256, 512, 768, -256, 512, -256, 768, 512, 16'd1, 1));
		// tie: the earlier triangle keeps the hit
		send_triangle(flat_tri(-256, -256, 512, 768, -256, 512, -256, 768, 512, 16'd2, 0));
		send_triangle(flat_tri(-256, -256, 512, 768, -256, 512, -256, 768, 512, 16'd3, 1));
		// far then near: the nearer replaces
		send_triangle(flat_tri(-256, -256, 2048, 768, -256, 2048, -256, 768, 2048, 16'd5, 0));
		send_triangle(flat_tri(-256, -256, 300, 768, -256, 300, -256, 768, 300, 16'd6, 1));
		// hit at distance zero
		send_triangle(flat_tri(-256, -256, 0, 768, -256, 0, -256, 768, 0, 16'hFFFF, 1));
		// behind the origin, degenerate, and outside: no hit
		send_triangle(flat_tri(-256, -256, -512, 768, -256, -512, -256, 768, -512, 16'd7, 0));
		send_triangle(flat_tri(5, 5, 5, 5, 5, 5, 5, 5, 5, 16'd8, 0));
		send_triangle(flat_tri(1024, 1024, 512, 2048, 1024, 512, 1024, 2048, 512, 16'd9, 1));
		// coordinate extremes
		send_triangle(flat_tri(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
			32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 16'd0, 0));
		send_triangle(flat_tri(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 1));
		flush_stream();

		// tiny direction and a far plane: distance saturates
		set_ray(0, 0, 0, 0, 0, 1);
		send_triangle(flat_tri(-256, -256, 32'h40000000, 768, -256, 32'h40000000,
			-256, 768, 32'h40000000, 16'h1234, 0));
		send_triangle(flat_tri(-256, -256, 32'h40000000, 768, -256, 32'h40000000,
			-256, 768, 32'h40000000, 16'h4321, 1));
		flush_stream();

		// zero direction: every determinant is zero
		set_ray(100, -100, 7, 0, 0, 0);
		random_phase(12);

		// register extremes
		set_ray(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000);
		random_phase(20);
		set_ray(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
			32'h7FFFFFFF);
		random_phase(20);

		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 7)
				set_ray($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
			else
				set_ray($signed($urandom_range(0, 4096)) - 2048,
					$signed($urandom_range(0, 4096)) - 2048,
					$signed($urandom_range(0, 4096)) - 2048,
					$signed($urandom_range(0, 2048)) - 1024,
					$signed($urandom_range(0, 2048)) - 1024,
					$signed($urandom_range(0, 2048)) - 1024);
			random_phase(125);
		end

		$display("sent %0d triangles, %0d of them hits; checked %0d closest-hit results",
			n_sent, sb.n_hits, sb.n_checked);
		$display("ray settings covered zero, extreme and random origins and directions");
		if (sb.errors == 0 && sb.pending_hits.size() == 0)
			$display("tb_ray_triangle_closest_hit_top: done, clean");
		else
			$display("tb_ray_triangle_closest_hit_top: done, errors");
		$finish;
	end
endmodule
`default_nettype wire
